// ===== rtl/core/tcrs_pkg.sv =====
// Package for the trade candle ring store: item structs, codes and ring size.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcrs_pkg;

  // Number of bars the ring holds; the stored_count and read_offset widths are fixed and sized for it.
  localparam int CAPACITY = 4096;

  localparam logic [1:0] KIND_TRADE = 2'd0;
  localparam logic [1:0] KIND_APPLY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OLDER   = 2'd1;
  localparam logic [1:0] ST_IVZERO  = 2'd2;
  localparam logic [1:0] ST_BEYOND  = 2'd3;

  localparam logic [0:0] CFG_INTERVAL = 1'b0;
  localparam logic [0:0] CFG_TAG      = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] time_ms;
    logic [63:0] candle_close_time;
    logic [31:0] candle_open_px;
    logic [31:0] candle_high_px;
    logic [31:0] candle_low_px;
    logic [31:0] price;
    logic [63:0] quantity;
    logic [31:0] candle_trade_count;
    logic [7:0]  candle_tag;
    logic [11:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] stored_count;
    logic [63:0] bar_open_time;
    logic [63:0] bar_close_time;
    logic [31:0] bar_open_px;
    logic [31:0] bar_high_px;
    logic [31:0] bar_low_px;
    logic [31:0] bar_close_px;
    logic [63:0] bar_volume;
    logic [31:0] bar_trades;
    logic [7:0]  bar_tag;
  } out_item_t;

  typedef struct packed {
    logic [63:0] open_time;
    logic [63:0] close_time;
    logic [31:0] open_px;
    logic [31:0] high_px;
    logic [31:0] low_px;
    logic [31:0] close_px;
    logic [63:0] volume;
    logic [31:0] trades;
    logic [7:0]  tag;
  } bar_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    in_item_t    item;
    logic        iv_zero;
    logic [63:0] bucket;
    logic [63:0] bucket_close;
    logic [7:0]  tag;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcrs_front.sv =====
// Front part: accepts items, computes the trade bucket with a bit-serial
// remainder unit, and pushes classified jobs into a two-entry queue.
// Depends on tcrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcrs_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  tcrs_pkg::in_item_t   in_item,
  input  wire  [31:0]          interval_len,
  input  wire  [7:0]           bar_tag_cfg,
  output logic                 job_valid,
  output tcrs_pkg::job_t       job,
  input  wire                  job_pop
);
  import tcrs_pkg::*;

  logic          div_busy_r, div_busy_nxt;
  logic [6:0]    bit_r, bit_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic          pend_r, pend_nxt;
  in_item_t      hold_r;
  logic [31:0]   iv_r;
  logic [7:0]    tag_r;

  job_t          q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          accept;
  job_t          push_job;
  logic [32:0]   trial;

  // hold off while dividing, while a job waits for its push, or when the queue is full
  assign busy   = div_busy_r || pend_r || (cnt_r == 2'd2);
  assign accept = start && !busy;

  always_comb begin
    trial = {rem_r[31:0], hold_r.time_ms[bit_r[5:0]]};
    div_busy_nxt = div_busy_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    pend_nxt = 1'b0;
    push_job.item         = hold_r;
    push_job.iv_zero      = (iv_r == 32'd0);
    push_job.bucket       = hold_r.time_ms - {31'd0, rem_r};
    push_job.bucket_close = push_job.bucket + {32'd0, iv_r} - 64'd1;
    push_job.tag          = tag_r;
    if (div_busy_r) begin
      // shift in one dividend bit per cycle, MSB first
      rem_nxt = (trial >= {1'b0, iv_r}) ? trial - {1'b0, iv_r} : trial;
      bit_nxt = bit_r - 7'd1;
      if (bit_r == 7'd0) begin
        // remainder is final after this edge; push on the next cycle
        div_busy_nxt = 1'b0;
        pend_nxt     = 1'b1;
      end
    end
    if (accept) begin
      rem_nxt = 33'd0;
      if (in_item.kind == KIND_TRADE && interval_len != 32'd0) begin
        div_busy_nxt = 1'b1;
        bit_nxt      = 7'd63;
      end else begin
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      pend_r     <= 1'b0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      bit_r <= 7'd0;
    end else begin
      div_busy_r <= div_busy_nxt;
      bit_r      <= bit_nxt;
      rem_r      <= rem_nxt;
      pend_r     <= pend_nxt;
      if (pend_r) begin
        q_r[wp_r] <= push_job;
        wp_r <= ~wp_r;
      end
      if (job_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, pend_r} - {1'b0, job_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_item;
      iv_r   <= interval_len;
      tag_r  <= bar_tag_cfg;
    end
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
endmodule
`default_nettype wire

// ===== rtl/core/tcrs_back.sv =====
// Back part: ring memory, newest-bar read-modify-write, reads and clears.
// Depends on tcrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcrs_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 job_valid,
  input  tcrs_pkg::job_t      job,
  output logic                job_pop,
  output logic                res_valid,
  output tcrs_pkg::out_item_t res,
  output logic                idle
);
  import tcrs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd2;

  bar_t          mem [CAPACITY];
  bar_t          rd_r;
  logic [1:0]    state_r;
  job_t          job_r;
  logic [AW-1:0] oldest_r;
  logic [CW-1:0] total_r;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   sum;
  logic [CW-1:0] pos;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] c;
    c = v;
    if (c >= (AW+1)'(CAPACITY)) c = c - (AW+1)'(CAPACITY);
    return c[AW-1:0];
  endfunction

  // position from oldest of the bar the job needs
  always_comb begin
    if (job.item.kind == KIND_READ) begin
      pos = total_r - CW'(1) - CW'(job.item.read_offset);
    end else begin
      pos = total_r - CW'(1);
    end
    sum = {1'b0, oldest_r} + (AW+1)'(pos);
    rd_addr = wrap(sum);
  end

  logic          have;
  logic          full;
  logic [AW-1:0] newest;
  logic [AW-1:0] app_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  bar_t          wr_bar;
  out_item_t     o;
  logic [CW-1:0] tot_nxt;
  logic [AW-1:0] old_nxt;
  logic [64:0]   vsum;

  always_comb begin
    have    = (total_r != '0);
    full    = (total_r == CW'(CAPACITY));
    newest  = wrap({1'b0, oldest_r} + (AW+1)'(total_r - CW'(1)));
    app_slot = full ? oldest_r : wrap({1'b0, oldest_r} + (AW+1)'(total_r));
    wr_en   = 1'b0;
    wr_addr = app_slot;
    wr_bar  = rd_r;
    o       = '0;
    o.status = ST_DONE;
    tot_nxt = total_r;
    old_nxt = oldest_r;
    vsum    = {1'b0, rd_r.volume} + {1'b0, job_r.item.quantity};
    case (job_r.item.kind)
      KIND_TRADE: begin
        if (job_r.iv_zero) begin
          o.status = ST_IVZERO;
        end else if (have && job_r.bucket < rd_r.open_time) begin
          o.status = ST_OLDER;
        end else if (have && job_r.bucket == rd_r.open_time) begin
          wr_en = 1'b1;
          wr_addr = newest;
          wr_bar.close_px = job_r.item.price;
          if (job_r.item.price > rd_r.high_px) wr_bar.high_px = job_r.item.price;
          if (job_r.item.price < rd_r.low_px) wr_bar.low_px = job_r.item.price;
          wr_bar.volume = vsum[64] ? '1 : vsum[63:0];
          if (rd_r.trades != '1) wr_bar.trades = rd_r.trades + 32'd1;
        end else begin
          wr_en = 1'b1;
          wr_bar.open_time  = job_r.bucket;
          wr_bar.close_time = job_r.bucket_close;
          wr_bar.open_px    = job_r.item.price;
          wr_bar.high_px    = job_r.item.price;
          wr_bar.low_px     = job_r.item.price;
          wr_bar.close_px   = job_r.item.price;
          wr_bar.volume     = job_r.item.quantity;
          wr_bar.trades     = 32'd1;
          wr_bar.tag        = job_r.tag;
        end
      end
      KIND_APPLY: begin
        wr_en = 1'b1;
        if (have && rd_r.open_time == job_r.item.time_ms) wr_addr = newest;
        wr_bar.open_time  = job_r.item.time_ms;
        wr_bar.close_time = job_r.item.candle_close_time;
        wr_bar.open_px    = job_r.item.candle_open_px;
        wr_bar.high_px    = job_r.item.candle_high_px;
        wr_bar.low_px     = job_r.item.candle_low_px;
        wr_bar.close_px   = job_r.item.price;
        wr_bar.volume     = job_r.item.quantity;
        wr_bar.trades     = job_r.item.candle_trade_count;
        wr_bar.tag        = job_r.item.candle_tag;
      end
      KIND_CLEAR: begin
        tot_nxt = '0;
        old_nxt = '0;
      end
      default: begin
        if (13'(job_r.item.read_offset) >= 13'(total_r)) begin
          o.status = ST_BEYOND;
        end else begin
          o.bar_open_time  = rd_r.open_time;
          o.bar_close_time = rd_r.close_time;
          o.bar_open_px    = rd_r.open_px;
          o.bar_high_px    = rd_r.high_px;
          o.bar_low_px     = rd_r.low_px;
          o.bar_close_px   = rd_r.close_px;
          o.bar_volume     = rd_r.volume;
          o.bar_trades     = rd_r.trades;
          o.bar_tag        = rd_r.tag;
        end
      end
    endcase
    if (wr_en && wr_addr == app_slot && !(job_r.item.kind == KIND_TRADE &&
        have && job_r.bucket == rd_r.open_time)) begin
      if (!(job_r.item.kind == KIND_APPLY && have &&
            rd_r.open_time == job_r.item.time_ms)) begin
        if (full) old_nxt = wrap({1'b0, oldest_r} + (AW+1)'(1));
        else      tot_nxt = total_r + CW'(1);
      end
    end
    o.stored_count = 13'(tot_nxt);
  end

  assign job_pop = (state_r == S_IDLE) && job_valid;
  assign idle    = (state_r == S_IDLE) && !job_valid;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      rd_r  <= mem[rd_addr];
      job_r <= job;
    end
    if (state_r == S_EXEC && wr_en) begin
      mem[wr_addr] <= wr_bar;
    end
    res <= o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      oldest_r  <= '0;
      total_r   <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= (state_r == S_EXEC);
      unique case (state_r)
        S_IDLE: if (job_valid) state_r <= S_EXEC;
        S_EXEC: begin
          state_r   <= S_IDLE;
          total_r   <= tot_nxt;
          oldest_r  <= old_nxt;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/trade_candle_ring_store_top.sv =====
// Top level of the trade candle ring store: front classifier, job queue, back ring.
// Depends on tcrs_pkg, tcrs_front, tcrs_back.
//
//  channel | ports                              | handshake
//  input   | start, busy, in_item               | taken when start && !busy
//  result  | out_valid, out_item                | one cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_data        | written when cfg_we
//
// In the front, a trade's bucket remainder is found by a bit-serial restoring
// divider, one time bit per cycle, then the job is pushed. Other kinds, and
// trades with a zero interval, skip the divider and are pushed in the cycle
// after acceptance. The back runs each job as a memory read, then update and
// write; the result strobe follows. The front can take the next item before the
// back has given the last result. busy rises while the divider runs, while a job
// waits for its push, or while the two-entry job queue is full.
// Reset is synchronous and clears counts; ring contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module trade_candle_ring_store_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  tcrs_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output tcrs_pkg::out_item_t  out_item,
  input  wire                  cfg_we,
  input  wire  [0:0]           cfg_index,
  input  wire  [31:0]          cfg_data
);
  import tcrs_pkg::*;

  logic [31:0] interval_r;
  logic [7:0]  tag_r;
  logic        job_valid, job_pop, back_idle;
  job_t        job;

  // hold config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 32'd60000;
      tag_r      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_data;
        default:      tag_r      <= cfg_data[7:0];
      endcase
    end
  end

  tcrs_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .interval_len(interval_r), .bar_tag_cfg(tag_r),
    .job_valid(job_valid), .job(job), .job_pop(job_pop)
  );

  tcrs_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
    .job_pop(job_pop), .res_valid(out_valid), .res(out_item), .idle(back_idle)
  );

  // a result strobe is never followed directly by another
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  // stored count never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.stored_count <= 13'(CAPACITY)))
    else $error("stored count too large");
  // idle back means no strobe next cycle
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    back_idle |=> !out_valid) else $error("result without job");
endmodule
`default_nettype wire
